// ----- src/time_based_event_debouncer_top_assert.svh -----
// Assertion macros used by the debouncer checker.
`ifndef TIME_BASED_EVENT_DEBOUNCER_TOP_ASSERT_SVH
`define TIME_BASED_EVENT_DEBOUNCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TBED_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbed assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TBED_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbed assertion failed");

`endif

// ----- src/tbed_pkg.sv -----
// Types and constants of the time based event debouncer.
package tbed_pkg;

	localparam int LIM_W    = 16;
	localparam int IN_W     = 80;
	localparam int OUT_W    = 24;
	localparam int CFG_IX_W = 8;
	localparam int Q_DEPTH  = 2;

	// register indexes
	localparam logic [CFG_IX_W-1:0] CFG_FDC_FLAG   = 8'd0;
	localparam logic [CFG_IX_W-1:0] CFG_ENTRY_FDC  = 8'd1;
	localparam logic [CFG_IX_W-1:0] CFG_SUSPICIOUS = 8'd2;
	localparam logic [CFG_IX_W-1:0] CFG_DIST_MEM   = 8'd3;

	// input tdata bit positions
	localparam int ID_LSB   = 0;
	localparam int RS_LSB   = 8;
	localparam int TF_BIT   = 10;
	localparam int TOC_BIT  = 11;
	localparam int SUPP_BIT = 12;
	localparam int PLIM_LSB = 13;
	localparam int FLIM_LSB = 29;
	localparam int FDCL_LSB = 45;
	localparam int SUSL_LSB = 61;

	localparam logic signed [LIM_W-1:0] SUSP_OFF = 16'sd32767;

	typedef enum logic [2:0] {
		LS_PASSED    = 3'd0,
		LS_FAILED    = 3'd1,
		LS_PREPASSED = 3'd2,
		LS_PREFAILED = 3'd3,
		LS_NONE      = 3'd4
	} last_status_t;

	typedef enum logic [1:0] {
		OS_NONE      = 2'd0,
		OS_PASSED    = 2'd1,
		OS_FAILED    = 2'd2,
		OS_PREFAILED = 2'd3
	} out_status_t;

	typedef enum logic [1:0] {
		K_REPORT = 2'd0,
		K_TICK   = 2'd1,
		K_HOLD   = 2'd2,
		K_SKIP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		BK_CLEAR  = 2'd0,
		BK_IDLE   = 2'd1,
		BK_LOOKUP = 2'd2
	} back_state_t;

	typedef struct packed {
		logic en_fdc;
		logic en_entry;
		logic en_susp;
		logic en_dm;
	} cfg_t;

	typedef struct packed {
		kind_t                    kind;
		logic [7:0]               event_id;
		logic [1:0]               rep_status;
		logic                     test_failed;
		logic                     test_complete_toc;
		logic signed [LIM_W-1:0]  passed_limit;
		logic signed [LIM_W-1:0]  failed_limit;
		logic signed [LIM_W-1:0]  fdc_limit;
		logic signed [LIM_W-1:0]  suspicious_limit;
	} item_t;

	typedef struct packed {
		last_status_t             status;
		logic signed [LIM_W-1:0]  level;
	} entry_t;

	// laid out as m_axis_tdata, lowest field last
	typedef struct packed {
		logic                     dist_mem_passed;
		logic                     allow_buffer_insert;
		logic                     suspicious_clear;
		logic                     suspicious_set;
		logic                     fdc_reached_clear;
		logic                     fdc_reached_set;
		logic [LIM_W-1:0]         debounce_level;
		out_status_t              status_to_report;
	} result_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_ctl_t;

endpackage

// ----- src/tbed_ram.sv -----
// Generic single-port-write, registered-read RAM.
module tbed_ram #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/tbed_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
module tbed_front #(
	parameter int NUM_EVENTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [tbed_pkg::IN_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  tbed_pkg::back_ctl_t  ctl,
	output logic                 q_valid,
	output tbed_pkg::item_t      q_item
);
	import tbed_pkg::*;

	localparam int QPW = $clog2(Q_DEPTH);

	item_t           entries_q [Q_DEPTH];
	logic [QPW-1:0]  wr_ptr_q;
	logic [QPW-1:0]  rd_ptr_q;
	logic [QPW:0]    count_q;
	item_t           cls;
	logic            in_range;
	logic            push;

	// classify the incoming request
	always_comb begin
		in_range = 32'(s_axis_tdata[ID_LSB +: 8]) < 32'(NUM_EVENTS);
		cls.event_id          = s_axis_tdata[ID_LSB +: 8];
		cls.rep_status        = s_axis_tdata[RS_LSB +: 2];
		cls.test_failed       = s_axis_tdata[TF_BIT];
		cls.test_complete_toc = s_axis_tdata[TOC_BIT];
		cls.passed_limit      = s_axis_tdata[PLIM_LSB +: LIM_W];
		cls.failed_limit      = s_axis_tdata[FLIM_LSB +: LIM_W];
		cls.fdc_limit         = s_axis_tdata[FDCL_LSB +: LIM_W];
		cls.suspicious_limit  = s_axis_tdata[SUSL_LSB +: LIM_W];
		priority if (!in_range) begin
			cls.kind = K_SKIP;
		end else if (!s_axis_tuser) begin
			cls.kind = K_REPORT;
		end else if (s_axis_tdata[SUPP_BIT]) begin
			cls.kind = K_HOLD;
		end else begin
			cls.kind = K_TICK;
		end
	end

	assign s_axis_tready = (count_q != (QPW+1)'(Q_DEPTH)) && !ctl.clearing;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = count_q != '0;
	assign q_item        = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && ctl.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/tbed_back.sv -----
// Back end: per-event state lookup, debounce update and result register.
module tbed_back #(
	parameter int NUM_EVENTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tbed_pkg::cfg_t        cfg,
	input  logic                  q_valid,
	input  tbed_pkg::item_t       q_item,
	output tbed_pkg::back_ctl_t   ctl,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [tbed_pkg::OUT_W-1:0] m_axis_tdata
);
	import tbed_pkg::*;

	localparam int AW = $clog2(NUM_EVENTS);
	localparam int EW = $bits(entry_t);

	back_state_t  state_q;
	back_state_t  state_d;
	logic [AW-1:0] clr_q;
	logic          clr_last;
	item_t         work_q;
	logic          out_valid_q;
	result_t       out_q;
	logic          out_free;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic          ram_re;
	logic [EW-1:0] ram_rdata;
	entry_t        rd_entry;
	entry_t        nxt;
	result_t       res;
	logic          load_out;
	logic          wr_back;

	logic signed [LIM_W-1:0] lvl;
	logic signed [LIM_W-1:0] plim;
	logic signed [LIM_W-1:0] flim;
	logic signed [LIM_W-1:0] fdcl;
	logic signed [LIM_W-1:0] susl;
	last_status_t rs;
	logic          susp_on;
	logic          fdc_any;

	assign clr_last = clr_q == AW'(NUM_EVENTS - 1);
	assign out_free = !out_valid_q || m_axis_tready;
	assign rd_entry = entry_t'(ram_rdata);

	tbed_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_EVENTS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (EW'(ram_wdata)),
		.re    (ram_re),
		.raddr (AW'(q_item.event_id)),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR:  if (clr_last) state_d = BK_IDLE;
			BK_IDLE:   if (q_valid) state_d = BK_LOOKUP;
			BK_LOOKUP: if (out_free) state_d = BK_IDLE;
			default:   state_d = BK_CLEAR;
		endcase
	end

	// debounce update on the looked-up entry
	always_comb begin
		res     = '0;
		nxt     = rd_entry;
		lvl     = rd_entry.level;
		plim    = work_q.passed_limit;
		flim    = work_q.failed_limit;
		fdcl    = work_q.fdc_limit;
		susl    = work_q.suspicious_limit;
		rs      = last_status_t'({1'b0, work_q.rep_status});
		susp_on = cfg.en_susp && (susl != SUSP_OFF);
		fdc_any = cfg.en_fdc || cfg.en_entry;
		unique case (work_q.kind)
			K_REPORT: begin
				res.dist_mem_passed = cfg.en_dm && (rs == LS_PASSED || rs == LS_PREPASSED)
					&& (lvl < flim) && (rd_entry.status == LS_PREFAILED);
				nxt.status = rs;
				if (rs == LS_PASSED) begin
					lvl                  = plim;
					res.suspicious_clear = susp_on;
					res.fdc_reached_clear = cfg.en_fdc;
				end else if (rs == LS_FAILED) begin
					lvl                 = flim;
					res.fdc_reached_set = fdc_any;
				end
			end
			K_TICK: begin
				case (rd_entry.status)
					LS_PREPASSED: begin
						if (lvl > plim) begin
							if (lvl > 16'sd0) lvl = 16'sd0;
							lvl = lvl - 16'sd1;
							if (lvl == plim) res.status_to_report = OS_PASSED;
						end else if (!work_q.test_complete_toc) begin
							res.status_to_report = OS_PASSED;
						end
						res.fdc_reached_clear = cfg.en_fdc;
						res.suspicious_clear  = susp_on;
					end
					LS_PREFAILED: begin
						if (lvl < flim) begin
							if (lvl < 16'sd0) lvl = 16'sd0;
							lvl = lvl + 16'sd1;
							if (lvl == flim) res.status_to_report = OS_FAILED;
							if (fdc_any && lvl >= fdcl) begin
								res.fdc_reached_set = 1'b1;
								if (cfg.en_entry && res.status_to_report != OS_FAILED) begin
									res.status_to_report    = OS_PREFAILED;
									res.allow_buffer_insert = 1'b1;
								end
							end
							res.suspicious_set = susp_on && (lvl >= susl);
						end else if (!work_q.test_failed) begin
							res.status_to_report = OS_FAILED;
							res.fdc_reached_set  = fdc_any;
						end
					end
					LS_PASSED: begin
						lvl = plim;
						if (work_q.test_failed) res.status_to_report = OS_PASSED;
						res.fdc_reached_clear = cfg.en_fdc;
						res.suspicious_clear  = susp_on;
					end
					LS_FAILED: begin
						lvl = flim;
						if (!work_q.test_failed) begin
							res.status_to_report = OS_FAILED;
							res.fdc_reached_set  = fdc_any;
						end
					end
					default: ;
				endcase
			end
			K_HOLD: ;
			K_SKIP: lvl = 16'sd0;
			default: ;
		endcase
		nxt.level          = lvl;
		res.debounce_level = lvl;
	end

	// control outputs per state
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = AW'(work_q.event_id);
		ram_wdata   = nxt;
		ram_re      = 1'b0;
		ctl.pop     = 1'b0;
		ctl.clearing = 1'b0;
		load_out    = 1'b0;
		wr_back     = (work_q.kind == K_REPORT) || (work_q.kind == K_TICK);
		unique case (state_q)
			BK_CLEAR: begin
				ctl.clearing     = 1'b1;
				ram_we           = 1'b1;
				ram_waddr        = clr_q;
				ram_wdata.status = LS_NONE;
				ram_wdata.level  = '0;
			end
			BK_IDLE: begin
				ctl.pop = q_valid;
				ram_re  = q_valid;
			end
			BK_LOOKUP: begin
				load_out = out_free;
				ram_we   = out_free && wr_back;
			end
			default: ctl.clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			work_q <= q_item;
		end
		if (load_out) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_q);

endmodule

// ----- src/time_based_event_debouncer_top.sv -----
// Top level of the per-event time based debouncer.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: report or tick request, tuser: opcode
//  m_axis   | out | m_axis_tvalid/tready   | tdata: one result per request
//  cfg      | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data (bit per register)
//
// The back end takes one request at a time: the registered read of the event's
// state RAM, then the update and write-back once the result register is free.
// After reset a clearing pass writes every entry with s_axis_tready low;
// configuration writes are taken throughout.
// A two-entry queue sits between front and back, and the result register
// frees the back end as soon as m_axis_tready takes the waiting result.
module time_based_event_debouncer_top #(
	parameter int NUM_EVENTS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_axis_tdata, from bit 0: event_id[8], reported_status[2], test_failed,
	// test_complete_toc, suppressed, passed_limit[16], failed_limit[16],
	// fdc_limit[16], suspicious_limit[16], zero pad[3]
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [tbed_pkg::IN_W-1:0]     s_axis_tdata,
	// s_axis_tuser: opcode (0 report, 1 tick)
	input  logic                          s_axis_tuser,
	// m_axis_tdata, from bit 0: status_to_report[2], debounce_level[16],
	// fdc_reached_set, fdc_reached_clear, suspicious_set, suspicious_clear,
	// allow_buffer_insert, dist_mem_passed
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [tbed_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tbed_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic                          cfg_data
);
	import tbed_pkg::*;

	cfg_t      cfg_q;
	back_ctl_t ctl;
	logic      q_valid;
	item_t     q_item;

	// config regs are always writable; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FDC_FLAG:   cfg_q.en_fdc   <= cfg_data;
				CFG_ENTRY_FDC:  cfg_q.en_entry <= cfg_data;
				CFG_SUSPICIOUS: cfg_q.en_susp  <= cfg_data;
				CFG_DIST_MEM:   cfg_q.en_dm    <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept + classify + queue
	tbed_front #(
		.NUM_EVENTS (NUM_EVENTS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.ctl           (ctl),
		.q_valid       (q_valid),
		.q_item        (q_item)
	);

	// back: state RAM, debounce update, result register
	tbed_back #(
		.NUM_EVENTS (NUM_EVENTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.ctl           (ctl),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ----- src/tbed_checker.sv -----
// Port-level checker for the debouncer top, with its bind.
`include "time_based_event_debouncer_top_assert.svh"

module tbed_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [tbed_pkg::OUT_W-1:0] m_axis_tdata
);
	import tbed_pkg::*;

	// a stalled result stays put
	`TBED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// set and clear requests never come together
	`TBED_ASSERT_NOW(a_flag_excl, m_axis_tvalid, !(m_axis_tdata[18] && m_axis_tdata[19]) && !(m_axis_tdata[20] && m_axis_tdata[21]))

	// buffer insert only with a prefailed report and fdc reached
	`TBED_ASSERT_NOW(a_insert, m_axis_tvalid && m_axis_tdata[22], (m_axis_tdata[1:0] == OS_PREFAILED) && m_axis_tdata[18])

	// disturbance memory flag only on report results
	`TBED_ASSERT_NOW(a_dist_mem, m_axis_tvalid && m_axis_tdata[23], (m_axis_tdata[1:0] == OS_NONE) && !m_axis_tdata[22])

endmodule

bind time_based_event_debouncer_top tbed_checker u_tbed_checker (.*);

// ----- bench/tb_time_based_event_debouncer_top.sv -----
// Self-checking bench for the time based event debouncer: directed and random requests.
`timescale 1ns / 1ps

module tb_time_based_event_debouncer_top;
	import tbed_pkg::*;

	// tuser codes of the request channel
	localparam logic OP_REPORT = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// request payload, laid out exactly as s_axis_tdata (lowest field last)
	typedef struct packed {
		logic [2:0]              pad;
		logic signed [LIM_W-1:0] susp_lim;
		logic signed [LIM_W-1:0] fdc_lim;
		logic signed [LIM_W-1:0] fail_lim;
		logic signed [LIM_W-1:0] pass_lim;
		logic                    supp;
		logic                    toc;
		logic                    tf;
		logic [1:0]              rs;
		logic [7:0]              id;
	} req_body_t;

	typedef struct packed {
		logic      op;
		req_body_t body;
	} debounce_req_t;

	// per-event thresholds as carried by each request
	typedef struct packed {
		logic signed [LIM_W-1:0] pass_lim;
		logic signed [LIM_W-1:0] fail_lim;
		logic signed [LIM_W-1:0] fdc_lim;
		logic signed [LIM_W-1:0] susp_lim;
	} limits_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata = '0;
	logic                s_axis_tuser = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IX_W-1:0] cfg_index = '0;
	logic                cfg_data = 1'b0;

	time_based_event_debouncer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Predictor state: mirrors the block's per-event RAM and its registers.
	logic signed [LIM_W-1:0] level_mem  [256];
	last_status_t            status_mem [256];
	cfg_t                    mode_cfg = '0;

	debounce_req_t pending_requests  [$];
	result_t       predicted_results [$];
	int            requests_queued = 0;
	int            results_checked = 0;
	int            mismatches = 0;

	// Idle control. calm turns off all idling for the last stretch.
	logic          calm = 1'b0;
	int            tx_idle_pct = 0;
	int            rx_stall_pct = 0;
	int            tx_gap_left = 0;
	int            rx_stall_left = 0;

	logic [7:0]    hot_events [16];

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// One debounce step on the mirrored state; returns the result the block
	// must give for this request.
	function automatic result_t debounce_step(input debounce_req_t r);
		result_t      res;
		last_status_t prev;
		last_status_t rep;
		out_status_t  st;
		int           lv;
		int           plim;
		int           flim;
		int           fdcl;
		int           susl;
		logic         susp_on;
		logic         fdc_any;
		res = '0;
		st = OS_NONE;
		plim = $signed(r.body.pass_lim);
		flim = $signed(r.body.fail_lim);
		fdcl = $signed(r.body.fdc_lim);
		susl = $signed(r.body.susp_lim);
		susp_on = mode_cfg.en_susp && (r.body.susp_lim != SUSP_OFF);
		fdc_any = mode_cfg.en_fdc || mode_cfg.en_entry;
		lv = $signed(level_mem[r.body.id]);
		prev = status_mem[r.body.id];
		if (r.op == OP_REPORT) begin
			rep = last_status_t'({1'b0, r.body.rs});
			// disturbance memory looks at the status held before this report
			res.dist_mem_passed = mode_cfg.en_dm && (rep == LS_PASSED || rep == LS_PREPASSED)
				&& lv < flim && prev == LS_PREFAILED;
			status_mem[r.body.id] = rep;
			if (rep == LS_PASSED) begin
				lv = plim;
				res.suspicious_clear = susp_on;
				res.fdc_reached_clear = mode_cfg.en_fdc;
			end else if (rep == LS_FAILED) begin
				lv = flim;
				res.fdc_reached_set = fdc_any;
			end
		end else if (!r.body.supp) begin
			case (prev)
				LS_PREPASSED: begin
					if (lv > plim) begin
						// start from 0 at most; may overshoot a positive limit
						if (lv > 0)
							lv = 0;
						lv -= 1;
						if (lv == plim)
							st = OS_PASSED;
					end else if (!r.body.toc) begin
						st = OS_PASSED;
					end
					res.fdc_reached_clear = mode_cfg.en_fdc;
					res.suspicious_clear = susp_on;
				end
				LS_PREFAILED: begin
					if (lv < flim) begin
						if (lv < 0)
							lv = 0;
						lv += 1;
						if (lv == flim)
							st = OS_FAILED;
						if (fdc_any && lv >= fdcl) begin
							res.fdc_reached_set = 1'b1;
							if (mode_cfg.en_entry && st != OS_FAILED) begin
								st = OS_PREFAILED;
								res.allow_buffer_insert = 1'b1;
							end
						end
						if (susp_on && lv >= susl)
							res.suspicious_set = 1'b1;
					end else if (!r.body.tf) begin
						st = OS_FAILED;
						res.fdc_reached_set = fdc_any;
					end
				end
				LS_PASSED: begin
					lv = plim;
					if (r.body.tf)
						st = OS_PASSED;
					res.fdc_reached_clear = mode_cfg.en_fdc;
					res.suspicious_clear = susp_on;
				end
				LS_FAILED: begin
					lv = flim;
					if (!r.body.tf) begin
						st = OS_FAILED;
						res.fdc_reached_set = fdc_any;
					end
				end
				default: begin
					// no report yet: nothing moves
				end
			endcase
		end
		level_mem[r.body.id] = lv[LIM_W-1:0];
		res.status_to_report = st;
		res.debounce_level = lv[LIM_W-1:0];
		return res;
	endfunction

	// Request driver: presents queued requests, predicts each one as it is taken.
	always @(posedge clk) begin : request_driver
		debounce_req_t cur_req;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predicted_results.push_back(debounce_step(cur_req));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
						// start an idle burst, this cycle included; tx_gap_left holds the rest
						tx_gap_left = $urandom_range(0, 11);
						s_axis_tvalid <= 1'b0;
					end else begin
						cur_req = pending_requests.pop_front();
						s_axis_tvalid <= 1'b1;
						s_axis_tdata <= cur_req.body;
						s_axis_tuser <= cur_req.op;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string tag, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, tag, want, got);
			mismatches++;
		end
	endtask

	// Result monitor: random back-pressure, compares against the oldest prediction.
	always @(posedge clk) begin : result_monitor
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (predicted_results.size() == 0) begin
					$display("%0t: result with nothing expected, got %h", $time, m_axis_tdata);
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					check_field("status_to_report", want.status_to_report,
						got.status_to_report);
					check_field("debounce_level", $signed(want.debounce_level),
						$signed(got.debounce_level));
					check_field("fdc_reached_set", want.fdc_reached_set, got.fdc_reached_set);
					check_field("fdc_reached_clear", want.fdc_reached_clear,
						got.fdc_reached_clear);
					check_field("suspicious_set", want.suspicious_set, got.suspicious_set);
					check_field("suspicious_clear", want.suspicious_clear,
						got.suspicious_clear);
					check_field("allow_buffer_insert", want.allow_buffer_insert,
						got.allow_buffer_insert);
					check_field("dist_mem_passed", want.dist_mem_passed, got.dist_mem_passed);
					results_checked++;
				end
			end
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
				rx_stall_left = $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// One register write; the mirrored register follows at the handshake.
	task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (ix)
			CFG_FDC_FLAG:   mode_cfg.en_fdc = val;
			CFG_ENTRY_FDC:  mode_cfg.en_entry = val;
			CFG_SUSPICIOUS: mode_cfg.en_susp = val;
			CFG_DIST_MEM:   mode_cfg.en_dm = val;
			default: ;
		endcase
	endtask

	task automatic apply_mode(input cfg_t m);
		write_reg(CFG_FDC_FLAG, m.en_fdc);
		write_reg(CFG_ENTRY_FDC, m.en_entry);
		write_reg(CFG_SUSPICIOUS, m.en_susp);
		write_reg(CFG_DIST_MEM, m.en_dm);
	endtask

	// Sender holds off until every request has its result back; registers
	// are only touched after this.
	task automatic drain();
		while (results_checked != requests_queued)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic send(input logic op, input logic [7:0] id, input last_status_t rs,
		input logic tf, input logic toc, input logic supp, input limits_t l);
		debounce_req_t r;
		r.op = op;
		r.body.pad = '0;
		r.body.id = id;
		// status field is don't-care on ticks, so let its bits roam
		r.body.rs = (op == OP_TICK) ? 2'($urandom) : rs[1:0];
		r.body.tf = tf;
		r.body.toc = toc;
		r.body.supp = supp;
		r.body.pass_lim = l.pass_lim;
		r.body.fail_lim = l.fail_lim;
		r.body.fdc_lim = l.fdc_lim;
		r.body.susp_lim = l.susp_lim;
		pending_requests.push_back(r);
		requests_queued++;
	endtask

	// Small limits so tick runs reach them; sometimes full-range or crossed.
	function automatic limits_t pick_limits(input logic wild);
		limits_t l;
		int      roll;
		int      pl;
		int      fl;
		roll = $urandom_range(0, 9);
		if (wild || roll < 2) begin
			l.pass_lim = 16'($urandom);
			l.fail_lim = 16'($urandom);
			l.fdc_lim = 16'($urandom);
			l.susp_lim = ($urandom_range(0, 7) == 0) ? SUSP_OFF : 16'($urandom);
			return l;
		end
		pl = -int'($urandom_range(1, 12));
		fl = $urandom_range(1, 12);
		if (roll == 3) begin
			// crossed limits: first step from 0 jumps past them
			pl = $urandom_range(1, 6);
			fl = -int'($urandom_range(1, 6));
		end
		l.pass_lim = 16'(pl);
		l.fail_lim = 16'(fl);
		l.fdc_lim = 16'(fl - int'($urandom_range(0, 3)));
		l.susp_lim = (roll == 2) ? SUSP_OFF : 16'(fl - int'($urandom_range(0, 4)));
		return l;
	endfunction

	// Mostly monitor-like runs: a report then a string of ticks on a busy
	// event, sometimes a closing report; the rest is raw noise.
	task automatic run_random(input int n);
		int           made;
		int           nt;
		int           k;
		int           kind;
		logic [7:0]   ev;
		limits_t      lim;
		last_status_t opening;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 99) < 15) begin
				send(1'($urandom), 8'($urandom), last_status_t'(3'($urandom_range(0, 3))),
					1'($urandom), 1'($urandom), 1'($urandom), pick_limits(1'b1));
				made++;
			end else begin
				ev = hot_events[$urandom_range(0, 15)];
				lim = pick_limits(1'b0);
				kind = $urandom_range(0, 9);
				opening = (kind < 4) ? LS_PREFAILED : (kind < 7) ? LS_PREPASSED :
					(kind == 7) ? LS_PASSED : LS_FAILED;
				if (kind < 9) begin
					send(OP_REPORT, ev, opening, 1'($urandom), 1'($urandom), 1'($urandom), lim);
					made++;
				end
				nt = $urandom_range(1, 14);
				for (k = 0; k < nt; k++)
					send(OP_TICK, ev, LS_PASSED, 1'($urandom), 1'($urandom),
						$urandom_range(0, 11) == 0, lim);
				made += nt;
				if ($urandom_range(0, 1) == 1) begin
					send(OP_REPORT, ev, last_status_t'(3'($urandom_range(0, 3))),
						1'($urandom), 1'($urandom), 1'($urandom), lim);
					made++;
				end
			end
		end
	endtask

	initial begin : stimulus
		limits_t edge_lim;
		limits_t tight;
		limits_t low_start;
		int      i;
		int      ph;
		for (i = 0; i < 256; i++) begin
			level_mem[i] = '0;
			status_mem[i] = LS_NONE;
		end
		hot_events[0] = 8'd0;
		hot_events[1] = 8'd255;
		for (i = 2; i < 16; i++)
			hot_events[i] = 8'($urandom_range(1, 254));

		// extreme thresholds, suspicious handling off
		edge_lim.pass_lim = 16'sh8000;
		edge_lim.fail_lim = 16'sh7fff;
		edge_lim.fdc_lim = 16'sh8000;
		edge_lim.susp_lim = SUSP_OFF;
		tight.pass_lim = -16'sd3;
		tight.fail_lim = 16'sd3;
		tight.fdc_lim = 16'sd2;
		tight.susp_lim = 16'sd1;
		low_start.pass_lim = -16'sd5;
		low_start.fail_lim = -16'sd2;
		low_start.fdc_lim = -16'sd5;
		low_start.susp_lim = -16'sd5;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, every feature on
		tx_idle_pct = 20;
		rx_stall_pct = 20;
		apply_mode(4'b1111);
		send(OP_TICK, 8'd0, LS_PASSED, 1'b1, 1'b0, 1'b0, tight);      // never reported
		send(OP_REPORT, 8'd255, LS_PASSED, 1'b0, 1'b0, 1'b0, edge_lim);
		send(OP_TICK, 8'd255, LS_PASSED, 1'b1, 1'b1, 1'b0, edge_lim);
		send(OP_REPORT, 8'd1, LS_FAILED, 1'b0, 1'b0, 1'b0, tight);
		send(OP_TICK, 8'd1, LS_PASSED, 1'b0, 1'b0, 1'b0, tight);
		send(OP_TICK, 8'd1, LS_PASSED, 1'b1, 1'b0, 1'b0, tight);
		// prefailed up to the limit: suspicious, fdc entry, then failed
		send(OP_REPORT, 8'd2, LS_PREFAILED, 1'b0, 1'b0, 1'b0, tight);
		for (i = 0; i < 3; i++)
			send(OP_TICK, 8'd2, LS_PASSED, 1'b1, 1'b0, 1'b0, tight);
		send(OP_TICK, 8'd2, LS_PASSED, 1'b0, 1'b0, 1'b0, tight);      // at limit, not failed
		send(OP_REPORT, 8'd2, LS_PREPASSED, 1'b0, 1'b0, 1'b0, tight); // level not below limit
		// disturbance memory passed, then prepassed run down to the limit
		send(OP_REPORT, 8'd3, LS_PREFAILED, 1'b0, 1'b0, 1'b0, tight);
		send(OP_TICK, 8'd3, LS_PASSED, 1'b0, 1'b0, 1'b0, tight);
		send(OP_REPORT, 8'd3, LS_PREPASSED, 1'b0, 1'b0, 1'b0, tight);
		for (i = 0; i < 4; i++)
			send(OP_TICK, 8'd3, LS_PASSED, 1'b0, 1'b0, 1'b0, tight);
		send(OP_TICK, 8'd3, LS_PASSED, 1'b0, 1'b1, 1'b0, tight);      // test completed
		send(OP_TICK, 8'd3, LS_PASSED, 1'b0, 1'b0, 1'b1, tight);      // suppressed
		// overshoot: negative failed limit, level clamped to 0 then steps past it
		send(OP_REPORT, 8'd4, LS_PASSED, 1'b0, 1'b0, 1'b0, low_start);
		send(OP_REPORT, 8'd4, LS_PREFAILED, 1'b0, 1'b0, 1'b0, low_start);
		send(OP_TICK, 8'd4, LS_PASSED, 1'b1, 1'b0, 1'b0, low_start);
		send(OP_TICK, 8'd4, LS_PASSED, 1'b0, 1'b0, 1'b0, low_start);
		drain();

		// random phases: all off, all on, then random settings; last one calm
		for (ph = 0; ph < 6; ph++) begin
			calm = (ph == 5);
			tx_idle_pct = calm ? 0 : $urandom_range(0, 2) * 15;
			rx_stall_pct = calm ? 0 : $urandom_range(0, 2) * 15;
			apply_mode((ph == 0) ? cfg_t'(4'b0000) : (ph == 1) ? cfg_t'(4'b1111) :
				cfg_t'(4'($urandom)));
			run_random(75);
			drain();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/tbed_pkg.sv
src/tbed_ram.sv
src/tbed_front.sv
src/tbed_back.sv
src/time_based_event_debouncer_top.sv
src/tbed_checker.sv
bench/tb_time_based_event_debouncer_top.sv
